/* hw/rtl/tshi_pkg.sv */
// tshi_pkg: shared types and constants for the timed sample history interpolator
// used by tshi_div, timed_sample_history_interpolator_top and tb, no dependencies
`timescale 1ns / 1ps

package tshi_pkg;

  // register indexes on the configuration port
  localparam logic CFG_RING_SIZE = 1'b0;
  localparam logic CFG_INTERVAL  = 1'b1;

  // register reset values
  localparam logic [4:0]  RING_SIZE_RST = 5'd10;
  localparam logic [15:0] INTERVAL_RST  = 16'd50;

  // lookup status codes
  localparam logic [1:0] STAT_INTERP = 2'd0;
  localparam logic [1:0] STAT_SHORT  = 2'd1;
  localparam logic [1:0] STAT_OLD    = 2'd2;

  // field widths
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned KW     = TIME_W + 1;    // intervals back, n + 1
  localparam int unsigned TW     = 18;            // interpolation offset t
  localparam int unsigned PW     = TW + 1 + ANG_W + 1; // signed product t * (a - b)
  localparam int unsigned DIV_W  = 50;            // magnitude of the product
  localparam int unsigned SUM_W  = DIV_W + 3;     // older sample plus signed quotient

  // divider: two quotient bits per cycle
  localparam int unsigned STEP_W     = 5;
  localparam logic [STEP_W-1:0] STEPS_TIME = STEP_W'(TIME_W / 2);
  localparam logic [STEP_W-1:0] STEPS_PROD = STEP_W'(DIV_W / 2);

  // divider request
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

/* hw/rtl/tshi_div.sv */
// tshi_div: iterative unsigned restoring divider, two quotient bits per cycle
// depends on tshi_pkg
`timescale 1ns / 1ps

module tshi_div
  import tshi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  input  logic [DIV_W-1:0]  dividend_i,   // left aligned, top 2*steps bits used
  input  logic [TIME_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [DIV_W-1:0]  quotient_o,
  output logic [TIME_W-1:0] remainder_o
);

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] div_q;

  // two restoring steps per cycle
  always_comb begin
    logic [TIME_W:0] trial;
    rem_d = rem_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, dvd_d[DIV_W-1]};
      dvd_d = {dvd_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = TIME_W'(trial - {1'b0, div_q});
        quo_d = {quo_d[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[TIME_W-1:0];
        quo_d = {quo_d[DIV_W-2:0], 1'b0};
      end
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= dividend_i;
      quo_q <= '0;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* hw/rtl/timed_sample_history_interpolator_top.sv */
// Timed sample history interpolator: a ring of Q16.16 angle samples taken at a fixed
// interval, answered by linear interpolation at a timestamp. A store beat writes the
// ring when accepted and leaves the input ready. A query beat runs one shared divider
// twice (intervals back, then the scaled difference over the interval) around two
// reads of the sample memory and one multiply; a fallback result (history too short
// or too old) skips the multiply and the second division. The input is not ready
// while a query is in work; a finished result waits in the output register.
// depends on tshi_pkg and tshi_div
`timescale 1ns / 1ps

module timed_sample_history_interpolator_top
  import tshi_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // sample_angle[31:0], query_time[47:32], now_time[63:48]
  input  logic        s_axis_tuser,   // req_type[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // angle_out[31:0]
  output logic [1:0]  m_axis_tuser    // lookup_status[1:0]
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV1 = 8'b0000_0010,
    ST_RDA  = 8'b0000_0100,
    ST_RDB  = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_LOAD = 8'b0010_0000,
    ST_DIV2 = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [4:0]  ring_size_q;
  logic [15:0] interval_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= RING_SIZE_RST;
      interval_q  <= INTERVAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RING_SIZE: ring_size_q <= cfg_data_i[4:0];
        CFG_INTERVAL:  interval_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective size and interval
  logic [15:0]       rs_ext, s_clamp;
  logic [AW:0]       size_eff;
  logic [TIME_W-1:0] iv_eff;

  always_comb begin
    rs_ext = {11'b0, ring_size_q};
    if (rs_ext < 16'd2) begin
      s_clamp = 16'd2;
    end else if (rs_ext > 16'(RING_DEPTH)) begin
      s_clamp = 16'(RING_DEPTH);
    end else begin
      s_clamp = rs_ext;
    end
    size_eff = s_clamp[AW:0];
    iv_eff   = (interval_q == '0) ? 16'd1 : interval_q;
  end

  // input beat fields
  logic              in_query;
  logic [ANG_W-1:0]  in_angle;
  logic [TIME_W-1:0] in_qtime, in_now, in_dist;
  logic              in_acc;

  assign in_query      = s_axis_tuser;
  assign in_angle      = s_axis_tdata[31:0];
  assign in_qtime      = s_axis_tdata[47:32];
  assign in_now        = s_axis_tdata[63:48];
  assign in_dist       = (in_now >= in_qtime) ? in_now - in_qtime : in_qtime - in_now;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // write position and filled flag
  logic [AW-1:0] wpos_q;
  logic          filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= '0;
      filled_q <= 1'b0;
    end else if (in_acc && !in_query) begin
      if (({1'b0, wpos_q} + (AW+1)'(1)) < size_eff) begin
        wpos_q <= wpos_q + AW'(1);
      end else begin
        wpos_q   <= '0;
        filled_q <= 1'b1;
      end
    end
  end

  // sample memory, registered read
  logic [ANG_W-1:0] ring_mem [RING_DEPTH];
  logic [ANG_W-1:0] rdata_q;
  logic [AW-1:0]    ia_q, ib_q, rd_addr;

  assign rd_addr = (state_q == ST_RDB) ? ib_q : ia_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && !in_query) begin
      ring_mem[wpos_q] <= in_angle;
    end
    rdata_q <= ring_mem[rd_addr];
  end

  // shared divider
  div_req_t          div_req;
  logic [DIV_W-1:0]  div_dvd;
  logic              div_busy;
  logic [DIV_W-1:0]  div_quo;
  logic [TIME_W-1:0] div_rem;

  tshi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (iv_eff),
    .busy_o     (div_busy),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // query registers
  logic [TIME_W-1:0] qtime_q, now_q, dist_q;
  logic [TW-1:0]     t_q;
  logic              fb_q;
  logic [1:0]        stat_q;
  logic [ANG_W-1:0]  a_q;
  logic [ANG_W-1:0]  b_q;
  logic signed [PW-1:0] prod_q;
  logic              neg_q;
  logic [ANG_W-1:0]  res_q;

  // slot choice once the interval count is known
  logic [KW-1:0]      k_val, p_ext, s_ext, ia_full;
  logic [AW-1:0]      ia_val, ib_val;
  logic               fb_val;
  logic [1:0]         stat_val;
  logic signed [19:0] t_full;

  always_comb begin
    k_val = KW'(div_quo[TIME_W-1:0]) + KW'(1);
    p_ext = KW'(wpos_q);
    s_ext = KW'(size_eff);
    ia_full = (k_val <= p_ext) ? p_ext - k_val : p_ext + s_ext - k_val;
    ia_val  = ia_full[AW-1:0];
    ib_val  = (ia_val == '0) ? AW'(size_eff - (AW+1)'(1)) : ia_val - AW'(1);
    fb_val   = 1'b0;
    stat_val = STAT_INTERP;
    if (k_val < p_ext) begin
      fb_val = 1'b0;
    end else if (k_val < s_ext || k_val == p_ext) begin
      if (!filled_q) begin
        fb_val   = 1'b1;
        stat_val = STAT_SHORT;
        ia_val   = '0;
      end
    end else begin
      fb_val = 1'b1;
      if (filled_q) begin
        stat_val = STAT_OLD;
        ia_val   = wpos_q;
      end else begin
        stat_val = STAT_SHORT;
        ia_val   = '0;
      end
    end
    // t = query - (now - iv * k), with iv * n = dist - remainder
    t_full = $signed({4'b0, qtime_q}) - $signed({4'b0, now_q})
           + $signed({4'b0, TIME_W'(dist_q - div_rem)}) + $signed({4'b0, iv_eff});
  end

  // multiply and final sum
  logic signed [ANG_W:0]  diff;
  logic signed [PW-1:0]   prod;
  logic [PW-1:0]          prod_mag;
  logic signed [SUM_W-1:0] quo_s, sum;
  logic [ANG_W-1:0]       sat_val;

  always_comb begin
    diff     = $signed({rdata_q[ANG_W-1], rdata_q}) - $signed({a_q[ANG_W-1], a_q});
    diff     = -diff;
    prod     = PW'($signed({1'b0, t_q}) * diff);
    prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    quo_s    = neg_q ? -$signed({3'b0, div_quo}) : $signed({3'b0, div_quo});
    sum      = quo_s + SUM_W'($signed(b_q));
    if (sum > $signed(SUM_W'(32'sh7FFF_FFFF))) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (sum < -$signed(SUM_W'(33'sh0_8000_0000))) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = sum[ANG_W-1:0];
    end
  end

  // divider start
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEPS_TIME;
    div_dvd       = {in_dist, (DIV_W-TIME_W)'(0)};
    if (in_acc && in_query) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_LOAD) begin
      div_req.start = 1'b1;
      div_req.steps = STEPS_PROD;
      div_dvd       = prod_mag[DIV_W-1:0];
    end
  end

  // sequencer
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && in_query) state_d = ST_DIV1;
      ST_DIV1: if (!div_busy) state_d = ST_RDA;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = fb_q ? ST_FIN : ST_MUL;
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV2;
      ST_DIV2: if (!div_busy) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && in_query) begin
      qtime_q <= in_qtime;
      now_q   <= in_now;
      dist_q  <= in_dist;
    end
    if (state_q == ST_DIV1 && !div_busy) begin
      ia_q   <= ia_val;
      ib_q   <= ib_val;
      fb_q   <= fb_val;
      stat_q <= stat_val;
      t_q    <= t_full[TW-1:0];
    end
    if (state_q == ST_RDB) begin
      a_q <= rdata_q;
      if (fb_q) begin
        res_q <= rdata_q;
      end
    end
    if (state_q == ST_MUL) begin
      b_q    <= rdata_q;
      prod_q <= prod;
    end
    if (state_q == ST_LOAD) begin
      neg_q <= prod_q[PW-1];
    end
    if (state_q == ST_DIV2 && !div_busy) begin
      res_q <= sat_val;
    end
  end

  // output register
  logic             out_valid_q;
  logic [ANG_W-1:0] out_angle_q;
  logic [1:0]       out_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_angle_q <= res_q;
      out_stat_q  <= stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_angle_q;
  assign m_axis_tuser  = out_stat_q;

  // checks
  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STAT_INTERP || m_axis_tuser == STAT_SHORT ||
                       m_axis_tuser == STAT_OLD))
    else $error("result beat carries an unknown status");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result beat raised outside the finish step");

  a_query_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_query) |=> (state_q == ST_DIV1 && div_busy))
    else $error("query beat did not start the divider");

endmodule

/* tb/sv/tb.sv */
// tb: self-checking bench for timed_sample_history_interpolator_top, a scoreboard class
// predicts every query beat from its own copy of the ring and both registers
// depends on tshi_pkg and timed_sample_history_interpolator_top
`timescale 1ns / 1ps

import tshi_pkg::*;

localparam int unsigned RING_SLOTS = 16;
localparam longint     ANGLE_MAX  = 64'sd2147483647;
localparam longint     ANGLE_MIN  = -64'sd2147483648;

typedef enum logic {
  REQ_STORE = 1'b0,
  REQ_QUERY = 1'b1
} req_kind_e;

typedef struct packed {
  req_kind_e   kind;
  logic [31:0] angle;
  logic [15:0] query_time;
  logic [15:0] now_time;
} req_t;

typedef struct packed {
  logic [31:0] angle;
  logic [1:0]  status;
} result_t;

class angle_history_scoreboard;
  logic [31:0] ring_copy [RING_SLOTS];
  bit          stored    [RING_SLOTS];
  int unsigned write_slot;
  bit          wrapped;
  logic [4:0]  size_reg;
  logic [15:0] interval_reg;
  result_t     awaited [$];
  int unsigned faults;

  function new();
    write_slot   = 0;
    wrapped      = 1'b0;
    size_reg     = RING_SIZE_RST;
    interval_reg = INTERVAL_RST;
    faults       = 0;
    foreach (stored[i]) stored[i] = 1'b0;
  endfunction

  function void note_config(input logic index, input logic [15:0] value);
    if (index == CFG_RING_SIZE) size_reg = value[4:0];
    else interval_reg = value;
  endfunction

  // out-of-range sizes clamp to the ring bounds
  function int unsigned size_in_use();
    if (size_reg < 5'd2) return 2;
    if (32'(size_reg) > RING_SLOTS) return RING_SLOTS;
    return 32'(size_reg);
  endfunction

  function int unsigned interval_in_use();
    return (interval_reg == '0) ? 32'd1 : 32'(interval_reg);
  endfunction

  // slots read by a query, older < 0 when a single slot is returned
  function void plan_lookup(input logic [15:0] q, input logic [15:0] now,
                            output int newer, output int older,
                            output logic [1:0] status, output longint offset,
                            output longint iv);
    longint s, p, d, k;
    s      = longint'(size_in_use());
    p      = longint'(write_slot);
    iv     = longint'(interval_in_use());
    d      = (now >= q) ? longint'(now) - longint'(q) : longint'(q) - longint'(now);
    k      = d / iv + 1;
    offset = longint'(q) - (longint'(now) - iv * k);
    newer  = 0;
    older  = -1;
    status = STAT_INTERP;
    if (k < p) begin
      newer = int'(p - k);
      older = newer - 1;
    end else if (k == p) begin
      if (wrapped) older = int'(s - 1);
      else status = STAT_SHORT;
    end else if (k + 1 <= s) begin
      if (wrapped) begin
        newer = int'(p + s - k);
        older = newer - 1;
      end else begin
        status = STAT_SHORT;
      end
    end else if (wrapped) begin
      newer  = int'(p);
      status = STAT_OLD;
    end else begin
      status = STAT_SHORT;
    end
  endfunction

  function bit reads_unwritten(input logic [15:0] q, input logic [15:0] now);
    int         newer, older;
    logic [1:0] status;
    longint     offset, iv;
    plan_lookup(q, now, newer, older, status, offset, iv);
    return !stored[newer] || (older >= 0 && !stored[older]);
  endfunction

  // update the ring on a store beat, queue the answer on a query beat
  function void note_request(input req_t r);
    int         newer, older;
    logic [1:0] status;
    longint     offset, iv, a, b, v;
    result_t    res;
    if (r.kind == REQ_STORE) begin
      if (write_slot < RING_SLOTS) begin
        ring_copy[write_slot] = r.angle;
        stored[write_slot]    = 1'b1;
      end
      if (write_slot + 1 < size_in_use()) begin
        write_slot++;
      end else begin
        write_slot = 0;
        wrapped    = 1'b1;
      end
      return;
    end
    plan_lookup(r.query_time, r.now_time, newer, older, status, offset, iv);
    a = longint'(signed'(ring_copy[newer]));
    if (older < 0) begin
      v = a;
    end else begin
      b = longint'(signed'(ring_copy[older]));
      v = b + (offset * (a - b)) / iv;
    end
    if (v > ANGLE_MAX) v = ANGLE_MAX;
    else if (v < ANGLE_MIN) v = ANGLE_MIN;
    res.angle  = v[31:0];
    res.status = status;
    awaited.push_back(res);
  endfunction

  function void check_result(input logic [31:0] angle, input logic [1:0] status);
    result_t want;
    if (awaited.size() == 0) begin
      $error("unexpected beat: angle_out %h lookup_status %0d", angle, status);
      faults++;
      return;
    end
    want = awaited.pop_front();
    if (angle !== want.angle) begin
      $error("angle_out expected %h actual %h", want.angle, angle);
      faults++;
    end
    if (status !== want.status) begin
      $error("lookup_status expected %0d actual %0d", want.status, status);
      faults++;
    end
  endfunction
endclass

module tb;

  localparam int unsigned RX_OPEN  = 0;
  localparam int unsigned RX_COIN  = 1;
  localparam int unsigned RX_RUNS  = 2;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned N_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS = 70;

  localparam logic [4:0]  PHASE_SIZE     [N_PHASES] = '{16, 2, 0, 31, 7, 1, 12, 17, 4};
  localparam logic [15:0] PHASE_INTERVAL [N_PHASES] =
    '{1, 65535, 0, 13, 50, 3, 777, 9, 2000};
  localparam int unsigned PHASE_GAP      [N_PHASES] = '{0, 4, 20, 0, 8, 2, 30, 0, 5};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // sample_angle[31:0], query_time[47:32], now_time[63:48]
  logic        s_axis_tuser;   // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // angle_out[31:0]
  logic [1:0]  m_axis_tuser;   // lookup_status[1:0]

  angle_history_scoreboard sb;
  int unsigned rx_mode;
  int unsigned hold_requests;
  int unsigned gap_max;
  int unsigned burst_left;

  timed_sample_history_interpolator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("timed_sample_history_interpolator_top verification failed");
    $finish;
  end

  // result side: check each beat, then pick the next ready level
  initial begin : result_sink
    int unsigned hold_left, stall_left, holds_served;
    logic        rdy;
    hold_left    = 0;
    stall_left   = 0;
    holds_served = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        sb.check_result(m_axis_tdata, m_axis_tuser);
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_OPEN: rdy = 1'b1;
          RX_COIN: rdy = 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              rdy = 1'b0;
              stall_left--;
            end else begin
              rdy = 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 60);
            end
          end
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // present one request beat, then idle between bursts
  task automatic offer(input req_t r);
    int unsigned gap;
    s_axis_tdata  <= {r.now_time, r.query_time, r.angle};
    s_axis_tuser  <= r.kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_request(r);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic store_sample(input logic [31:0] angle);
    req_t r;
    r.kind       = REQ_STORE;
    r.angle      = angle;
    r.query_time = 16'($urandom);
    r.now_time   = 16'($urandom);
    offer(r);
  endtask

  task automatic ask_angle(input logic [15:0] q, input logic [15:0] now);
    req_t r;
    r.kind       = REQ_QUERY;
    r.angle      = $urandom;
    r.query_time = q;
    r.now_time   = now;
    offer(r);
  endtask

  // stop offering until every answer is back, then let the block settle
  task automatic drain(input int unsigned settle_cycles);
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic index, input logic [15:0] value);
    cfg_index_i <= index;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.note_config(index, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random request, queries aimed around the stored history
  function automatic req_t make_request(input bit want_query);
    req_t        r;
    int unsigned iv, span;
    r.kind = REQ_STORE;
    case ($urandom_range(0, 7))
      0:       r.angle = 32'h7fff_ffff;
      1:       r.angle = 32'h8000_0000;
      2:       r.angle = 32'($urandom_range(0, 131072)) - 32'd65536;
      default: r.angle = $urandom;
    endcase
    r.query_time = 16'($urandom);
    r.now_time   = 16'($urandom);
    if (!want_query) return r;
    iv   = sb.interval_in_use();
    span = (sb.size_in_use() + 2) * iv;
    for (int tries = 0; tries < 8; tries++) begin
      if ($urandom_range(0, 19) == 0)
        r.now_time = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
      case ($urandom_range(0, 9))
        0:       r.query_time = 16'($urandom);
        1:       r.query_time = 16'(r.now_time + $urandom_range(0, 3 * iv));
        default: r.query_time = 16'(r.now_time - $urandom_range(0, span));
      endcase
      if (!sb.reads_unwritten(r.query_time, r.now_time)) begin
        r.kind = REQ_QUERY;
        return r;
      end
      r.now_time = 16'($urandom);
    end
    return r;
  endfunction

  // stimulus
  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_RING_SIZE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_STORE;
    rx_mode       = RX_OPEN;
    hold_requests = 0;
    gap_max       = 3;
    burst_left    = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short history: first slot comes back, except one query that interpolates two samples
    store_sample(32'h7fff_ffff);
    ask_angle(16'd500, 16'd500);
    ask_angle(16'd0, 16'hffff);
    store_sample(32'h8000_0000);
    ask_angle(16'd480, 16'd500);
    ask_angle(16'hffff, 16'd0);
    // fill the ring until it wraps
    store_sample(32'h0000_0000);
    store_sample(32'h0000_0001);
    store_sample(32'hffff_ffff);
    store_sample(32'h0001_0000);
    store_sample(32'hfffe_ffff);
    store_sample(32'h1234_5678);
    store_sample(32'h4000_0000);
    store_sample(32'hc000_0000);
    // older than history, then the wrap-around pair
    ask_angle(16'd0, 16'd500);
    ask_angle(16'd455, 16'd500);
    store_sample(32'h0000_1000);
    store_sample(32'h8000_0000);
    store_sample(32'h7fff_ffff);
    // future timestamps extrapolate into saturation, both signs
    ask_angle(16'd140, 16'd100);
    store_sample(32'h8000_0000);
    ask_angle(16'd140, 16'd100);
    // intervals back equal to and past the write position
    ask_angle(16'd325, 16'd500);
    ask_angle(16'd225, 16'd500);

    // ring shrunk below the write position
    drain(50);
    write_reg(CFG_RING_SIZE, 16'd2);
    store_sample(32'h0abc_def0);
    ask_angle(16'd490, 16'd500);

    // random phases over a spread of register settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain(50);
      write_reg(CFG_RING_SIZE, (16'($urandom) & 16'hffe0) | 16'(PHASE_SIZE[ph]));
      write_reg(CFG_INTERVAL, PHASE_INTERVAL[ph]);
      rx_mode = ph % 3;
      gap_max = PHASE_GAP[ph];
      if (ph == 3 || ph == 7) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) drain(1);
        offer(make_request($urandom_range(0, 1) != 0));
      end
    end

    drain(60);
    if (sb.faults == 0 && sb.awaited.size() == 0) begin
      $display("timed_sample_history_interpolator_top verification clean");
    end else begin
      $display("timed_sample_history_interpolator_top verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tshi_pkg.sv
hw/rtl/tshi_div.sv
hw/rtl/timed_sample_history_interpolator_top.sv
tb/sv/tb.sv
